// ----- rtl/core/csrm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csrm_pkg: shared types and constants for the CpG strand record merger
// Base codes, sample count, beta constants and register indexes.
// ----------------------------------------------------------------------------
package csrm_pkg;

  localparam int unsigned SAMPLES = 4;

  localparam logic [1:0] BASE_C     = 2'd0;
  localparam logic [1:0] BASE_G     = 2'd1;
  localparam logic [1:0] BASE_OTHER = 2'd2;

  localparam logic [16:0] BETA_ONE = 17'd32768;

  localparam logic [1:0] REG_MIN_DEPTH = 2'd0;
  localparam logic [1:0] REG_NOME_MODE = 2'd1;

  // One sample's strand data as handed to the divider.
  typedef struct packed {
    logic [15:0] c_beta;
    logic [15:0] c_depth;
    logic [15:0] g_beta;
    logic [15:0] g_depth;
  } sample_t;

  function automatic logic [1:0] norm_base(input logic [1:0] b);
    norm_base = (b == 2'd3) ? BASE_OTHER : b;
  endfunction

endpackage

// ----- rtl/core/csrm_beta_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csrm_beta_unit: merged beta of one sample
// Two strand counts through one shared multiplier, then a radix-2 divider.
// ----------------------------------------------------------------------------
module csrm_beta_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  csrm_pkg::sample_t smp_i,
  output logic              done_o,
  output logic [15:0]       beta_o
);

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_MULC = 5'b00010,
    B_MULG = 5'b00100,
    B_DIV  = 5'b01000,
    B_DONE = 5'b10000
  } bstate_e;

  bstate_e     state_q, state_d;
  logic [17:0] num_q;       // rounded C strand count
  logic [17:0] cov_q;       // C depth plus G depth, one bit of headroom
  logic [33:0] rem_q;       // dividend shift register, 2*num*2^15 + cov
  logic [18:0] quo_q;
  logic [19:0] part_q;      // partial remainder
  logic [5:0]  cnt_q;

  logic [15:0] mul_a, mul_b;
  logic [31:0] prod;
  logic [16:0] cnt_rnd;
  logic [16:0] q_raw;
  logic [15:0] r_raw;
  logic [19:0] part_sh;
  logic [19:0] div2;

  assign mul_a = (state_q == B_MULC) ? smp_i.c_beta  : smp_i.g_beta;
  assign mul_b = (state_q == B_MULC) ? smp_i.c_depth : smp_i.g_depth;
  assign prod  = mul_a * mul_b;
  assign q_raw = prod[31:15];
  assign r_raw = {1'b0, prod[14:0]};
  // Ties round to even.
  assign cnt_rnd = q_raw + 17'((r_raw > 16'h4000) || (r_raw == 16'h4000 && q_raw[0]));

  assign part_sh = {part_q[18:0], rem_q[33]};
  assign div2    = {1'b0, cov_q, 1'b0};

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE:  if (start_i) state_d = B_MULC;
      B_MULC:  state_d = B_MULG;
      B_MULG:  state_d = B_DIV;
      B_DIV:   if (cnt_q == 6'd33) state_d = B_DONE;
      B_DONE:  state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == B_DIV) cnt_q <= cnt_q + 6'd1;
      else cnt_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        num_q <= '0;
        cov_q <= {2'b0, smp_i.c_depth} + {2'b0, smp_i.g_depth};
      end
      B_MULC: num_q <= {1'b0, cnt_rnd};
      B_MULG: begin
        rem_q  <= {(num_q + {1'b0, cnt_rnd}), 16'b0} + {16'b0, cov_q};
        part_q <= '0;
        quo_q  <= '0;
      end
      B_DIV: begin
        rem_q <= {rem_q[32:0], 1'b0};
        if (part_sh >= div2) begin
          part_q <= part_sh - div2;
          quo_q  <= {quo_q[17:0], 1'b1};
        end else begin
          part_q <= part_sh;
          quo_q  <= {quo_q[17:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  assign done_o = (state_q == B_DONE);
  always_comb begin
    if (cov_q == '0) beta_o = '0;
    else if (quo_q > {2'b0, csrm_pkg::BETA_ONE}) beta_o = csrm_pkg::BETA_ONE[15:0];
    else beta_o = quo_q[15:0];
  end

  a_mul_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_MULC |=> state_q == B_MULG) else $error("mul sequence broken");
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_DONE |-> $past(cnt_q) == 6'd33) else $error("divider length");
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && state_q == B_IDLE |=> state_q == B_MULC) else $error("start lost");

endmodule

// ----- rtl/core/cpg_strand_record_merger.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpg_strand_record_merger: pairs C and G strand records of a CpG site
// Holds one record, merges the G record that follows a C record, and
// reports the held record as one transaction per sample.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_ready  record fields, flush
// out      output     out_valid/out_ready per-sample result fields
// cfg      input      cfg_we_i           cfg_idx_i, cfg_data_i
//
// An input transaction that reports nothing leaves the block idle and ready.
// A reported record goes, per sample, through the shared multiply and
// divide unit (start, two multiplies, 34 divide steps, one result step),
// followed by an output handshake that waits for the receiver.
// Reset empties the held record; the block then accepts at once.
// in_ready is low from the acceptance of a record that reports until its last sample has been taken.
// ----------------------------------------------------------------------------
module cpg_strand_record_merger (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] chrom_id_i,
  input  logic [31:0] position_i,
  input  logic [1:0]  ref_base_i,
  input  logic [1:0]  base_before_i,
  input  logic [1:0]  base_after_i,
  input  logic [63:0] betas_i,
  input  logic [63:0] depths_i,
  input  logic        flush_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] chrom_out_o,
  output logic [31:0] start_out_o,
  output logic [32:0] end_out_o,
  output logic [1:0]  sample_index_o,
  output logic [15:0] merged_beta_o,
  output logic [16:0] coverage_o,
  output logic [15:0] c_beta_out_o,
  output logic [15:0] c_depth_out_o,
  output logic [15:0] g_beta_out_o,
  output logic [15:0] g_depth_out_o,
  output logic        last_sample_o
);

  localparam int unsigned S = csrm_pkg::SAMPLES;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CALC = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  state_e state_q;
  logic [15:0] min_depth_q;
  logic        nome_q;

  logic        hv_q;
  logic [15:0] hchrom_q;
  logic [31:0] hstart_q;
  logic [1:0]  href_q, hbefore_q, hafter_q;
  logic [15:0] hcb_q [S];
  logic [15:0] hcd_q [S];
  logic [15:0] hgb_q [S];
  logic [15:0] hgd_q [S];

  // Snapshot of the record being reported.
  logic [15:0] ochrom_q;
  logic [31:0] ostart_q;
  logic [32:0] oend_q;
  csrm_pkg::sample_t osmp_q [S];
  logic [1:0]  sidx_q;
  logic [15:0] obeta_q;
  logic        bstart_q;

  logic [1:0]  rb, bb, ba;
  logic        merge;
  logic        acc;
  logic [15:0] gb_eff [S];
  logic [15:0] gd_eff [S];
  logic [16:0] cov_s [S];
  logic [16:0] maxd;
  logic        report;
  logic [32:0] e_calc;
  logic [31:0] s_calc;
  logic        bdone;
  logic [15:0] bbeta;

  assign rb = csrm_pkg::norm_base(ref_base_i);
  assign bb = csrm_pkg::norm_base(base_before_i);
  assign ba = csrm_pkg::norm_base(base_after_i);

  assign in_ready_o = (state_q == ST_IDLE);
  assign acc = in_valid_i && in_ready_o;

  assign merge = !flush_i && hv_q && chrom_id_i == hchrom_q &&
                 {1'b0, position_i} == {1'b0, hstart_q} + 33'd1 &&
                 rb == csrm_pkg::BASE_G && href_q == csrm_pkg::BASE_C &&
                 (!nome_q || (hbefore_q != csrm_pkg::BASE_G && ba != csrm_pkg::BASE_C));

  // Coverage of the record that would be reported, G data already joined.
  always_comb begin
    maxd = '0;
    for (int i = 0; i < S; i++) begin
      gb_eff[i] = merge ? betas_i[16*i +: 16]  : hgb_q[i];
      gd_eff[i] = merge ? depths_i[16*i +: 16] : hgd_q[i];
      cov_s[i]  = {1'b0, hcd_q[i]} + {1'b0, gd_eff[i]};
      if (cov_s[i] > maxd) maxd = cov_s[i];
    end
  end
  assign report = hv_q && maxd != '0 && maxd >= {1'b0, min_depth_q};

  always_comb begin
    s_calc = hstart_q;
    e_calc = {1'b0, hstart_q} + 33'd1;
    if (href_q == csrm_pkg::BASE_C && hafter_q == csrm_pkg::BASE_G)
      e_calc = {1'b0, hstart_q} + 33'd2;
    else if (href_q == csrm_pkg::BASE_G && hbefore_q == csrm_pkg::BASE_C &&
             hstart_q != '0)
      s_calc = hstart_q - 32'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_depth_q <= '0;
      nome_q      <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == csrm_pkg::REG_MIN_DEPTH) min_depth_q <= cfg_data_i;
      else if (cfg_idx_i == csrm_pkg::REG_NOME_MODE) nome_q <= cfg_data_i[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      hv_q     <= 1'b0;
      sidx_q   <= '0;
      bstart_q <= 1'b0;
    end else begin
      bstart_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (acc) begin
            hv_q <= !flush_i && !merge;
            if (report) begin
              state_q  <= ST_CALC;
              sidx_q   <= '0;
              bstart_q <= 1'b1;
            end
          end
        end
        ST_CALC: if (bdone) state_q <= ST_OUT;
        ST_OUT: begin
          if (out_ready_i) begin
            if (sidx_q == 2'(S - 1)) state_q <= ST_IDLE;
            else begin
              sidx_q   <= sidx_q + 2'd1;
              state_q  <= ST_WAIT;
              bstart_q <= 1'b1;
            end
          end
        end
        ST_WAIT: state_q <= ST_CALC;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Held record and report snapshot; payload only.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      ochrom_q <= hchrom_q;
      ostart_q <= s_calc;
      oend_q   <= e_calc;
      for (int i = 0; i < S; i++) begin
        osmp_q[i].c_beta  <= hcb_q[i];
        osmp_q[i].c_depth <= hcd_q[i];
        osmp_q[i].g_beta  <= gb_eff[i];
        osmp_q[i].g_depth <= gd_eff[i];
      end
      if (!flush_i && !merge) begin
        hchrom_q  <= chrom_id_i;
        hstart_q  <= position_i;
        href_q    <= rb;
        hbefore_q <= bb;
        hafter_q  <= ba;
        for (int i = 0; i < S; i++) begin
          if (rb == csrm_pkg::BASE_G) begin
            hgb_q[i] <= betas_i[16*i +: 16];
            hgd_q[i] <= depths_i[16*i +: 16];
            hcb_q[i] <= '0;
            hcd_q[i] <= '0;
          end else begin
            hcb_q[i] <= betas_i[16*i +: 16];
            hcd_q[i] <= depths_i[16*i +: 16];
            hgb_q[i] <= '0;
            hgd_q[i] <= '0;
          end
        end
      end
    end
    if (bdone) obeta_q <= bbeta;
  end

  csrm_beta_unit u_beta (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (bstart_q),
    .smp_i   (osmp_q[sidx_q]),
    .done_o  (bdone),
    .beta_o  (bbeta)
  );

  assign out_valid_o    = (state_q == ST_OUT);
  assign chrom_out_o    = ochrom_q;
  assign start_out_o    = ostart_q;
  assign end_out_o      = oend_q;
  assign sample_index_o = sidx_q;
  assign merged_beta_o  = obeta_q;
  assign coverage_o     = {1'b0, osmp_q[sidx_q].c_depth} + {1'b0, osmp_q[sidx_q].g_depth};
  assign c_depth_out_o  = osmp_q[sidx_q].c_depth;
  assign g_depth_out_o  = osmp_q[sidx_q].g_depth;
  assign c_beta_out_o   = (osmp_q[sidx_q].c_depth != '0) ? osmp_q[sidx_q].c_beta : '0;
  assign g_beta_out_o   = (osmp_q[sidx_q].g_depth != '0) ? osmp_q[sidx_q].g_beta : '0;
  assign last_sample_o  = (sidx_q == 2'(S - 1));

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !in_ready_o) else $error("ready while busy");
  a_flush_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && flush_i |=> !hv_q) else $error("flush left a record");
  a_merge_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && merge |=> !hv_q) else $error("merge left a record");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_sample_o |=> state_q == ST_IDLE)
    else $error("record did not end");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the CpG strand record merger
// A directed table (reset, coordinate extremes, base code three, rounding
// ties, merges, zero coverage, flushes) is followed by random record streams
// under several register settings. Every accepted record is run through a
// local model of the merger and each output transaction is compared, field
// by field, with the oldest predicted one.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CLK_HALF = 4;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  // Idle long enough for any record that was still in flight to drain.
  localparam int unsigned DRAIN_CYCLES = 400;
  localparam int unsigned SQUEEZE_CYCLES = 2000;

  typedef struct packed {
    logic [15:0] chrom;
    logic [31:0] pos;
    logic [1:0]  ref_b;
    logic [1:0]  before_b;
    logic [1:0]  after_b;
    logic [63:0] betas;
    logic [63:0] depths;
    logic        flush;
  } record_t;

  typedef struct packed {
    logic [15:0] chrom;
    logic [31:0] start;
    logic [32:0] stop;
    logic [1:0]  sidx;
    logic [15:0] mbeta;
    logic [16:0] cov;
    logic [15:0] cbeta;
    logic [15:0] cdepth;
    logic [15:0] gbeta;
    logic [15:0] gdepth;
    logic        last;
  } site_t;

  // One row of the directed table. When fixed is set the row's outcome is
  // typed in: nothing at all, or one line repeated for every sample.
  typedef struct packed {
    record_t rec;
    logic    fixed;
    logic    reports;
    site_t   line;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [15:0] chrom_id_i;
  logic [31:0] position_i;
  logic [1:0]  ref_base_i;
  logic [1:0]  base_before_i;
  logic [1:0]  base_after_i;
  logic [63:0] betas_i;
  logic [63:0] depths_i;
  logic        flush_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] chrom_out_o;
  logic [31:0] start_out_o;
  logic [32:0] end_out_o;
  logic [1:0]  sample_index_o;
  logic [15:0] merged_beta_o;
  logic [16:0] coverage_o;
  logic [15:0] c_beta_out_o;
  logic [15:0] c_depth_out_o;
  logic [15:0] g_beta_out_o;
  logic [15:0] g_depth_out_o;
  logic        last_sample_o;

  cpg_strand_record_merger u_top (.*);

  // Model of the held record and the registers.
  logic [15:0] m_min_depth;
  logic        m_nome;
  logic        m_valid;
  logic [15:0] m_chrom;
  logic [31:0] m_start;
  logic [1:0]  m_ref, m_before, m_after;
  logic [15:0] m_cbeta [csrm_pkg::SAMPLES];
  logic [15:0] m_cdepth[csrm_pkg::SAMPLES];
  logic [15:0] m_gbeta [csrm_pkg::SAMPLES];
  logic [15:0] m_gdepth[csrm_pkg::SAMPLES];

  site_t       sites_due[$];
  int unsigned errors;
  int unsigned cycles;
  logic        calm;     // no idling on either side
  logic        squeeze;  // asks the receiver for one long hold-off
  int unsigned hold_left;
  logic [31:0] cur_pos;
  logic [15:0] cur_chrom;

  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  // Rounds beta times depth to a read count, ties to even.
  function automatic logic [16:0] strand_reads(logic [15:0] beta, logic [15:0] depth);
    logic [31:0] x;
    logic [16:0] q;
    x = beta * depth;
    q = x[31:15];
    if (x[14:0] > 15'h4000 || (x[14:0] == 15'h4000 && q[0])) q = q + 17'd1;
    return q;
  endfunction

  // Appends the per-sample lines of the held record if it is reportable.
  function automatic void report_held(ref site_t lines[$]);
    logic [16:0] maxd;
    logic [16:0] cov;
    logic [31:0] s;
    logic [32:0] e;
    logic [63:0] num;
    logic [63:0] mb;
    site_t       ln;
    maxd = '0;
    for (int i = 0; i < csrm_pkg::SAMPLES; i++) begin
      cov = m_cdepth[i] + m_gdepth[i];
      if (cov > maxd) maxd = cov;
    end
    if (maxd == 0 || maxd < {1'b0, m_min_depth}) return;
    s = m_start;
    e = {1'b0, m_start} + 33'd1;
    if (m_ref == csrm_pkg::BASE_C && m_after == csrm_pkg::BASE_G) e = e + 33'd1;
    else if (m_ref == csrm_pkg::BASE_G && m_before == csrm_pkg::BASE_C && s != 0)
      s = s - 32'd1;
    for (int i = 0; i < csrm_pkg::SAMPLES; i++) begin
      cov = m_cdepth[i] + m_gdepth[i];
      mb = '0;
      if (cov != 0) begin
        num = 64'(strand_reads(m_cbeta[i], m_cdepth[i]) +
                  64'(strand_reads(m_gbeta[i], m_gdepth[i]))) << 15;
        mb = (2 * num + cov) / (2 * 64'(cov));
        if (mb > 64'(csrm_pkg::BETA_ONE)) mb = 64'(csrm_pkg::BETA_ONE);
      end
      ln.chrom  = m_chrom;
      ln.start  = s;
      ln.stop   = e;
      ln.sidx   = i[1:0];
      ln.mbeta  = mb[15:0];
      ln.cov    = cov;
      ln.cbeta  = (m_cdepth[i] != 0) ? m_cbeta[i] : 16'd0;
      ln.cdepth = m_cdepth[i];
      ln.gbeta  = (m_gdepth[i] != 0) ? m_gbeta[i] : 16'd0;
      ln.gdepth = m_gdepth[i];
      ln.last   = (i == csrm_pkg::SAMPLES - 1);
      lines.push_back(ln);
    end
  endfunction

  // Advances the model by one accepted record and returns its output lines.
  function automatic void merge_record(record_t r, ref site_t lines[$]);
    logic [1:0]  rb, bb, ab;
    logic        join_g;
    logic [15:0] b, d;
    if (r.flush) begin
      if (m_valid) report_held(lines);
      m_valid = 1'b0;
      return;
    end
    // Base code three counts as "other".
    rb = (r.ref_b == 2'd3) ? csrm_pkg::BASE_OTHER : r.ref_b;
    bb = (r.before_b == 2'd3) ? csrm_pkg::BASE_OTHER : r.before_b;
    ab = (r.after_b == 2'd3) ? csrm_pkg::BASE_OTHER : r.after_b;
    join_g = m_valid && r.chrom == m_chrom && {1'b0, r.pos} == {1'b0, m_start} + 33'd1 &&
             rb == csrm_pkg::BASE_G && m_ref == csrm_pkg::BASE_C &&
             (!m_nome || (m_before != csrm_pkg::BASE_G && ab != csrm_pkg::BASE_C));
    if (join_g) begin
      for (int i = 0; i < csrm_pkg::SAMPLES; i++) begin
        m_gbeta[i]  = r.betas[16*i +: 16];
        m_gdepth[i] = r.depths[16*i +: 16];
      end
    end
    if (m_valid) report_held(lines);
    if (join_g) begin
      m_valid = 1'b0;
      return;
    end
    m_valid  = 1'b1;
    m_chrom  = r.chrom;
    m_start  = r.pos;
    m_ref    = rb;
    m_before = bb;
    m_after  = ab;
    for (int i = 0; i < csrm_pkg::SAMPLES; i++) begin
      b = r.betas[16*i +: 16];
      d = r.depths[16*i +: 16];
      m_cbeta[i]  = (rb == csrm_pkg::BASE_G) ? 16'd0 : b;
      m_cdepth[i] = (rb == csrm_pkg::BASE_G) ? 16'd0 : d;
      m_gbeta[i]  = (rb == csrm_pkg::BASE_G) ? b : 16'd0;
      m_gdepth[i] = (rb == csrm_pkg::BASE_G) ? d : 16'd0;
    end
  endfunction

  // Offers one record and waits for its transaction; the model runs at the
  // accepting edge. Valid is only lowered when a gap follows.
  task automatic offer(record_t r, logic fixed, logic reports, site_t line);
    site_t lines[$];
    in_valid_i    <= 1'b1;
    chrom_id_i    <= r.chrom;
    position_i    <= r.pos;
    ref_base_i    <= r.ref_b;
    base_before_i <= r.before_b;
    base_after_i  <= r.after_b;
    betas_i       <= r.betas;
    depths_i      <= r.depths;
    flush_i       <= r.flush;
    do @(posedge clk_i); while (!in_ready_o);
    merge_record(r, lines);
    if (fixed) begin
      lines.delete();
      if (reports) begin
        for (int i = 0; i < csrm_pkg::SAMPLES; i++) begin
          line.sidx = i[1:0];
          line.last = (i == csrm_pkg::SAMPLES - 1);
          lines.push_back(line);
        end
      end
    end
    foreach (lines[k]) sites_due.push_back(lines[k]);
    if (!calm && $urandom_range(99) < 38) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 38);
    end
  endtask

  // Register writes happen only with the block idle and drained.
  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    in_valid_i <= 1'b0;
    while (sites_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == csrm_pkg::REG_MIN_DEPTH) m_min_depth = data;
    else if (idx == csrm_pkg::REG_NOME_MODE) m_nome = data[0];
  endtask

  function automatic logic [15:0] pick_beta();
    case ($urandom_range(5))
      0:       return 16'd0;
      1:       return 16'(csrm_pkg::BETA_ONE);
      2:       return 16'($urandom());
      default: return 16'($urandom_range(32768));
    endcase
  endfunction

  function automatic logic [15:0] pick_depth();
    case ($urandom_range(7))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom());
      default: return 16'($urandom_range(40, 1));
    endcase
  endfunction

  function automatic record_t rand_record(logic [15:0] chrom, logic [31:0] pos, logic [1:0] rb);
    record_t r;
    r.chrom    = chrom;
    r.pos      = pos;
    r.ref_b    = rb;
    r.before_b = 2'($urandom());
    r.after_b  = 2'($urandom());
    r.flush    = 1'b0;
    for (int i = 0; i < csrm_pkg::SAMPLES; i++) begin
      r.betas[16*i +: 16]  = pick_beta();
      r.depths[16*i +: 16] = pick_depth();
    end
    return r;
  endfunction

  // Mostly C/G pairs one base apart, with a share of broken pairs, stray
  // records and flushes.
  task automatic random_stream(int unsigned count);
    record_t r;
    site_t   none;
    int unsigned sent;
    none = '0;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(9) == 0) cur_chrom = 16'($urandom());
      cur_pos = cur_pos + 32'($urandom_range(6, 2));
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: begin
          r = rand_record(cur_chrom, cur_pos, csrm_pkg::BASE_C);
          if ($urandom_range(3) != 0) r.after_b = csrm_pkg::BASE_G;
          offer(r, 1'b0, 1'b0, none);
          r = rand_record(cur_chrom, cur_pos + 32'd1, csrm_pkg::BASE_G);
          if ($urandom_range(3) != 0) r.before_b = csrm_pkg::BASE_C;
          if ($urandom_range(7) == 0) r.pos = r.pos + 32'd1;
          if ($urandom_range(11) == 0) r.chrom = r.chrom + 16'd1;
          cur_pos = cur_pos + 32'd1;
          offer(r, 1'b0, 1'b0, none);
          sent += 2;
        end
        6: begin
          r = '0;
          r.flush  = 1'b1;
          r.betas  = {$urandom(), $urandom()};
          r.depths = {$urandom(), $urandom()};
          r.chrom  = 16'($urandom());
          offer(r, 1'b0, 1'b0, none);
          sent += 1;
        end
        default: begin
          r = rand_record(cur_chrom, cur_pos, 2'($urandom()));
          if ($urandom_range(5) == 0) r.pos = $urandom();
          offer(r, 1'b0, 1'b0, none);
          sent += 1;
        end
      endcase
    end
  endtask

  function automatic record_t rec(logic [15:0] chrom, logic [31:0] pos, logic [1:0] rb,
                                  logic [1:0] bb, logic [1:0] ab, logic [63:0] betas,
                                  logic [63:0] depths, logic flush);
    record_t r;
    r = '{chrom, pos, rb, bb, ab, betas, depths, flush};
    return r;
  endfunction

  function automatic site_t line_of(logic [15:0] chrom, logic [31:0] s, logic [32:0] e,
                                    logic [15:0] mb, logic [16:0] cov, logic [15:0] cb,
                                    logic [15:0] cd, logic [15:0] gb, logic [15:0] gd);
    site_t ln;
    ln = '{chrom, s, e, 2'd0, mb, cov, cb, cd, gb, gd, 1'b0};
    return ln;
  endfunction

  // Stimulus: directed table, then random phases under several settings.
  initial begin
    row_t  table_rows[$];
    site_t none;
    none = '0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    chrom_id_i = '0;
    position_i = '0;
    ref_base_i = '0;
    base_before_i = '0;
    base_after_i = '0;
    betas_i = '0;
    depths_i = '0;
    flush_i = 1'b0;
    errors = 0;
    calm = 1'b0;
    squeeze = 1'b0;
    cur_pos = 32'd1000;
    cur_chrom = 16'd3;
    m_min_depth = '0;
    m_nome = 1'b0;
    m_valid = 1'b0;
    m_chrom = '0;
    m_start = '0;
    m_ref = csrm_pkg::BASE_OTHER;
    m_before = csrm_pkg::BASE_OTHER;
    m_after = csrm_pkg::BASE_OTHER;
    for (int i = 0; i < csrm_pkg::SAMPLES; i++) begin
      m_cbeta[i] = '0;
      m_cdepth[i] = '0;
      m_gbeta[i] = '0;
      m_gdepth[i] = '0;
    end

    // Flush with nothing held right after reset.
    table_rows.push_back('{rec(0, 0, 0, 0, 0, '1, '1, 1), 1'b1, 1'b0, none});
    // C at zero followed by G, full depth and beta one; nothing held before.
    table_rows.push_back('{rec(0, 0, csrm_pkg::BASE_C, csrm_pkg::BASE_OTHER,
                               csrm_pkg::BASE_G, {4{16'h8000}},
                               {4{16'hFFFF}}, 0), 1'b1, 1'b0, none});
    table_rows.push_back('{rec(0, 0, 0, 0, 0, 0, 0, 1), 1'b1, 1'b1,
                           line_of(0, 0, 2, 16'h8000, 17'd65535, 16'h8000, 16'hFFFF, 0, 0)});
    // G at start zero preceded by C: the start must not wrap.
    table_rows.push_back('{rec(16'hFFFF, 0, csrm_pkg::BASE_G, csrm_pkg::BASE_C,
                               csrm_pkg::BASE_OTHER, 0, {4{16'd1}}, 0),
                           1'b1, 1'b0, none});
    table_rows.push_back('{rec(0, 0, 0, 0, 0, 0, 0, 1), 1'b1, 1'b1,
                           line_of(16'hFFFF, 0, 1, 0, 17'd1, 0, 0, 0, 16'd1)});
    // Position of all ones: the G at zero is no neighbour.
    table_rows.push_back('{rec(5, '1, csrm_pkg::BASE_C, csrm_pkg::BASE_OTHER,
                               csrm_pkg::BASE_G, '1, '1, 0), 1'b1, 1'b0,
                           none});
    table_rows.push_back('{rec(5, 0, csrm_pkg::BASE_G, csrm_pkg::BASE_C,
                               csrm_pkg::BASE_OTHER, '1, '1, 0), 1'b0, 1'b0, none});
    // Ordinary CpG merge with mixed data.
    table_rows.push_back('{rec(5, 100, csrm_pkg::BASE_C, csrm_pkg::BASE_OTHER,
                               csrm_pkg::BASE_G, 64'h8000_4000_1234_0000,
                               64'h0000_0003_0001_FFFF, 0), 1'b0, 1'b0, none});
    table_rows.push_back('{rec(5, 101, csrm_pkg::BASE_G, csrm_pkg::BASE_C,
                               csrm_pkg::BASE_OTHER, 64'h4000_7FFF_0001_8000,
                               64'h0005_0003_0000_0002, 0), 1'b0, 1'b0, none});
    table_rows.push_back('{rec(0, 0, 0, 0, 0, 0, 0, 1), 1'b1, 1'b0, none});
    // Base code three in every base field.
    table_rows.push_back('{rec(5, 200, 2'd3, 2'd3, 2'd3, 64'h0003_8000_4000_2000,
                               64'h0001_0002_0003_0004, 0), 1'b1, 1'b0, none});
    // Zero depth everywhere, then a merge that stays at zero coverage.
    table_rows.push_back('{rec(5, 300, csrm_pkg::BASE_C, csrm_pkg::BASE_OTHER,
                               csrm_pkg::BASE_G, '1, 0, 0), 1'b0, 1'b0,
                           none});
    table_rows.push_back('{rec(5, 301, csrm_pkg::BASE_G, csrm_pkg::BASE_C,
                               csrm_pkg::BASE_OTHER, '1, 0, 0), 1'b1, 1'b0,
                           none});
    // Rounding ties of the read counts, and out-of-range betas.
    table_rows.push_back('{rec(7, 400, csrm_pkg::BASE_C, csrm_pkg::BASE_G,
                               csrm_pkg::BASE_G, 64'hFFFF_C000_4000_4000,
                               64'hFFFF_0003_0003_0001, 0), 1'b1, 1'b0, none});
    table_rows.push_back('{rec(7, 401, csrm_pkg::BASE_G, csrm_pkg::BASE_C,
                               csrm_pkg::BASE_C, 64'hFFFF_4000_4000_FFFF,
                               64'hFFFF_0001_0005_FFFF, 0), 1'b0, 1'b0, none});
    table_rows.push_back('{rec(7, 500, csrm_pkg::BASE_OTHER, csrm_pkg::BASE_G,
                               csrm_pkg::BASE_C, 64'h0000_0001_8000_7FFF,
                               64'h0000_0000_FFFF_0007, 0), 1'b1, 1'b0, none});
    table_rows.push_back('{rec(0, 0, 0, 0, 0, 0, 0, 1), 1'b0, 1'b0, none});

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (table_rows[k])
      offer(table_rows[k].rec, table_rows[k].fixed, table_rows[k].reports, table_rows[k].line);

    // Default settings, with the receiver's long hold-off.
    squeeze <= 1'b1;
    random_stream(80);
    squeeze <= 1'b0;
    write_reg(csrm_pkg::REG_NOME_MODE, 16'd1);
    random_stream(85);
    write_reg(csrm_pkg::REG_MIN_DEPTH, 16'hFFFF);
    write_reg(csrm_pkg::REG_NOME_MODE, 16'd0);
    calm <= 1'b1;
    random_stream(80);
    calm <= 1'b0;
    write_reg(csrm_pkg::REG_MIN_DEPTH, 16'($urandom_range(60, 2)));
    write_reg(csrm_pkg::REG_NOME_MODE, 16'hFFFE | 16'd1);
    random_stream(85);
    write_reg(csrm_pkg::REG_MIN_DEPTH, 16'($urandom()));
    write_reg(csrm_pkg::REG_NOME_MODE, 16'hFFFE);
    random_stream(45);
    write_reg(csrm_pkg::REG_MIN_DEPTH, 16'd0);
    random_stream(40);

    in_valid_i <= 1'b0;
    while (sites_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
      errors++;
    end
  endfunction

  // Receiver: random back-pressure, one long hold-off on request, the
  // checker, and the cycle limit.
  always @(posedge clk_i or negedge rst_ni) begin
    site_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left   <= 0;
      cycles      <= 0;
    end else begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        if (squeeze && hold_left == 0 && cycles < 40000 && $urandom_range(199) == 0)
          hold_left <= SQUEEZE_CYCLES;
        else if (hold_left > 1) hold_left <= hold_left - 1;
        if (hold_left > 1) out_ready_i <= 1'b0;
        else out_ready_i <= calm || ($urandom_range(99) >= 38);

        if (out_valid_o && out_ready_i) begin
          if (sites_due.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, actual sample %0d",
                     $realtime, sample_index_o);
            errors++;
          end else begin
            want = sites_due.pop_front();
            check_field("chrom_out", want.chrom, chrom_out_o);
            check_field("start_out", want.start, start_out_o);
            check_field("end_out", want.stop, end_out_o);
            check_field("sample_index", want.sidx, sample_index_o);
            check_field("merged_beta", want.mbeta, merged_beta_o);
            check_field("coverage", want.cov, coverage_o);
            check_field("c_beta_out", want.cbeta, c_beta_out_o);
            check_field("c_depth_out", want.cdepth, c_depth_out_o);
            check_field("g_beta_out", want.gbeta, g_beta_out_o);
            check_field("g_depth_out", want.gdepth, g_depth_out_o);
            check_field("last_sample", want.last, last_sample_o);
          end
        end
      end
    end
  end

endmodule

// ----- filelist.f -----
rtl/core/csrm_pkg.sv
rtl/core/csrm_beta_unit.sv
rtl/core/cpg_strand_record_merger.sv
tb/tb_top.sv
